### rtl/core/jss_pkg.sv
// Shared constants and register codes for the Jacobi stencil sweep core.
package jss_pkg;

    // Default build parameters
    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_VALUE_WIDTH = 24;
    localparam int DEF_FRAC_BITS   = 16;

    // Fixed field widths
    localparam int ROW_W      = 16;
    localparam int COLS_W     = 11;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_TOTAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_COLS = 2'd3;

    // Register reset values
    localparam logic [ROW_W-1:0]    RST_ROWS_TOTAL  = 16'd102;
    localparam logic [COLS_W-1:0]   RST_COLS_TOTAL  = 11'd102;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_ROWS = 16'd16384;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_COLS = 16'd16384;

    // Smallest grid extent along either axis
    localparam int MIN_EXTENT = 3;

endpackage

### rtl/core/jacobi_stencil_sweep_core.sv
// Top level of the Jacobi five-point stencil sweep core.
//
// One Jacobi sweep of the five-point Laplace stencil over a grid that streams
// in raster order, boundary rows and columns included, one signed fixed-point
// word per cycle. Each input word at (r, c) completes the stencil of interior
// point (r-1, c); for that point one result word is sent with the new value
// ((up+down)*weight_rows + (left+right)*weight_cols) / 2^FRAC_BITS, rounded
// half up and saturated, its row and column, the running maximum of
// |new - old| for the sweep, and tlast on the final interior point. Boundary
// inputs produce no result. A word with tuser set restarts the position at
// (0,0); the position also wraps by itself after the last grid point, and
// the first point of a sweep clears the running maximum. Throughput is one
// word per cycle while the result stream does not stall: the line stores
// are written once and read once per port for each accepted word. An
// accepted input passes the line store read on the accepting edge, then
// weight multiply, round and saturate, and change tracking into the output
// register. Row r-1 is kept in two identical RAM copies (center and right
// neighbor taps) and row r-2 in a third; the r-2 store is written in the
// cycle after the word that feeds it is read, with a bypass for a
// back-to-back read of the same column. Line stores need no clearing
// after reset. Configuration registers may only be written while the core
// is empty.
module jacobi_stencil_sweep_core #(
    parameter int MAX_COLS    = jss_pkg::DEF_MAX_COLS,
    parameter int VALUE_WIDTH = jss_pkg::DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = jss_pkg::DEF_FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // [VALUE_WIDTH-1:0] grid_value, zero padded to bytes
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]        s_tdata,
    // [0] sweep_start
    input  logic                                    s_tuser,
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // new_value, point_row (16), point_col, max_change; lowest first, padded
    output logic [((2*VALUE_WIDTH+jss_pkg::ROW_W+$clog2(MAX_COLS)+7)/8)*8-1:0]
                                                    m_tdata,
    // last_point
    output logic                                    m_tlast,
    // configuration write port
    input  logic                                    cfg_we,
    input  logic [jss_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [jss_pkg::CFG_DATA_W-1:0]          cfg_data
);

    import jss_pkg::*;

    localparam int AW        = $clog2(MAX_COLS);
    localparam int CE_W      = AW + 1;
    localparam int OUT_FIELD = 2*VALUE_WIDTH + ROW_W + AW;
    localparam int OUT_W     = ((OUT_FIELD + 7) / 8) * 8;
    localparam int SUM_W     = VALUE_WIDTH + 1;
    localparam int PROD_W    = SUM_W + WEIGHT_W + 1;
    localparam int ACC_W     = PROD_W + 1;

    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] VMAX = (ACC_W'(1) << (VALUE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] VMIN = ~VMAX;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [AW-1:0]    col;
        logic             interior;
        logic             last;
        logic             clr;
    } meta_t;

    // ---------------- configuration registers ----------------
    logic [ROW_W-1:0]    rows_total_reg;
    logic [COLS_W-1:0]   cols_total_reg;
    logic [WEIGHT_W-1:0] weight_rows_reg;
    logic [WEIGHT_W-1:0] weight_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_total_reg  <= RST_ROWS_TOTAL;
            cols_total_reg  <= RST_COLS_TOTAL;
            weight_rows_reg <= RST_WEIGHT_ROWS;
            weight_cols_reg <= RST_WEIGHT_COLS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROWS_TOTAL:  rows_total_reg  <= cfg_data;
                CFG_COLS_TOTAL:  cols_total_reg  <= cfg_data[COLS_W-1:0];
                CFG_WEIGHT_ROWS: weight_rows_reg <= cfg_data;
                CFG_WEIGHT_COLS: weight_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective extents: below three acts as three, columns capped at store depth
    logic [ROW_W-1:0] rows_eff;
    logic [CE_W-1:0]  cols_eff;

    always_comb
    begin
        rows_eff = (rows_total_reg < ROW_W'(MIN_EXTENT)) ? ROW_W'(MIN_EXTENT)
                                                         : rows_total_reg;
        if (32'(cols_total_reg) < 32'(MIN_EXTENT))
            cols_eff = CE_W'(MIN_EXTENT);
        else if (32'(cols_total_reg) > 32'(MAX_COLS))
            cols_eff = CE_W'(MAX_COLS);
        else
            cols_eff = CE_W'(cols_total_reg);
    end

    // ---------------- stage handshake ----------------
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en4;
    logic accept;

    assign en4      = !out_valid_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    // ---------------- position tracking ----------------
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [AW-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] r;
    logic [AW-1:0]    idx;
    logic [CE_W:0]    c_plus1, c_plus2;
    logic [ROW_W:0]   r_plus1;
    logic [CE_W-1:0]  nxt_col;
    logic             nxt_zero;
    logic [AW-1:0]    nxt_addr;
    meta_t            meta_in;

    always_comb
    begin
        r        = s_tuser ? '0 : row_cnt_reg;
        idx      = s_tuser ? '0 : col_cnt_reg;
        c_plus1  = (CE_W+1)'(idx) + (CE_W+1)'(1);
        c_plus2  = (CE_W+1)'(idx) + (CE_W+1)'(2);
        r_plus1  = (ROW_W+1)'(r) + (ROW_W+1)'(1);
        nxt_col  = CE_W'(idx) + CE_W'(1);
        nxt_zero = (32'(nxt_col) == 32'(MAX_COLS));
        nxt_addr = nxt_zero ? '0 : nxt_col[AW-1:0];

        meta_in.row      = r - ROW_W'(1);
        meta_in.col      = idx;
        meta_in.interior = (r >= ROW_W'(2)) && (r < rows_eff) && (idx != '0)
                           && (c_plus2 <= (CE_W+1)'(cols_eff));
        meta_in.last     = (r_plus1 == (ROW_W+1)'(rows_eff))
                           && (c_plus2 == (CE_W+1)'(cols_eff));
        meta_in.clr      = (r == '0) && (idx == '0);

        // raster advance with wrap at the grid end
        if (c_plus1 >= (CE_W+1)'(cols_eff))
        begin
            col_cnt_next = '0;
            row_cnt_next = (r_plus1 >= (ROW_W+1)'(rows_eff)) ? '0 : r_plus1[ROW_W-1:0];
        end
        else
        begin
            col_cnt_next = c_plus1[AW-1:0];
            row_cnt_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (accept)
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // ---------------- line stores ----------------
    // a_cur: row r-1 at c; a_nxt: row r-1 at c+1; b_cur: row r-2 at c
    logic [VALUE_WIDTH-1:0] grid_value;
    logic [VALUE_WIDTH-1:0] a_cur_rd, a_nxt_rd, b_cur_rd;
    logic                   b_pend_reg;
    logic [AW-1:0]          b_waddr_reg;

    assign grid_value = s_tdata[VALUE_WIDTH-1:0];

    jss_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_COLS)) u_line_a_cur (
        .clk   (clk),
        .we    (accept),
        .waddr (idx),
        .wdata (grid_value),
        .re    (accept),
        .raddr (idx),
        .rdata (a_cur_rd)
    );

    jss_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_COLS)) u_line_a_nxt (
        .clk   (clk),
        .we    (accept),
        .waddr (idx),
        .wdata (grid_value),
        .re    (accept),
        .raddr (nxt_addr),
        .rdata (a_nxt_rd)
    );

    // Row r-2 takes the old row r-1 word in the cycle after it was read
    jss_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_COLS)) u_line_b (
        .clk   (clk),
        .we    (b_pend_reg),
        .waddr (b_waddr_reg),
        .wdata (a_cur_rd),
        .re    (accept),
        .raddr (idx),
        .rdata (b_cur_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_pend_reg <= 1'b0;
        end
        else
        begin
            b_pend_reg <= accept;
        end
    end

    // ---------------- stage 1: line store outputs ----------------
    meta_t                  m1_reg;
    logic [VALUE_WIDTH-1:0] down1_reg, left1_reg, bypd1_reg;
    logic                   byp1_reg, nzero1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m1_reg      <= meta_in;
            down1_reg   <= grid_value;
            left1_reg   <= a_cur_rd;   // previous word's center tap
            bypd1_reg   <= a_cur_rd;
            byp1_reg    <= b_pend_reg && (b_waddr_reg == idx);
            nzero1_reg  <= nxt_zero;
            b_waddr_reg <= idx;
        end
    end

    logic [VALUE_WIDTH-1:0] up1, right1;
    logic signed [SUM_W-1:0]  s_rows, s_cols;
    logic signed [WEIGHT_W:0] w_rows, w_cols;
    logic signed [PROD_W-1:0] p_rows, p_cols;

    always_comb
    begin
        up1    = byp1_reg ? bypd1_reg : b_cur_rd;
        right1 = nzero1_reg ? '0 : a_nxt_rd;
        s_rows = $signed({up1[VALUE_WIDTH-1], up1})
               + $signed({down1_reg[VALUE_WIDTH-1], down1_reg});
        s_cols = $signed({left1_reg[VALUE_WIDTH-1], left1_reg})
               + $signed({right1[VALUE_WIDTH-1], right1});
        w_rows = $signed({1'b0, weight_rows_reg});
        w_cols = $signed({1'b0, weight_cols_reg});
        p_rows = s_rows * w_rows;
        p_cols = s_cols * w_cols;
    end

    // ---------------- stage 2: weighted products ----------------
    meta_t                    m2_reg;
    logic signed [PROD_W-1:0] p_rows2_reg, p_cols2_reg;
    logic [VALUE_WIDTH-1:0]   old2_reg;

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            m2_reg      <= m1_reg;
            p_rows2_reg <= p_rows;
            p_cols2_reg <= p_cols;
            old2_reg    <= a_cur_rd;
        end
    end

    logic signed [ACC_W-1:0] acc, acc_shr;
    logic [VALUE_WIDTH-1:0]  nv_sat;

    always_comb
    begin
        acc     = ACC_W'(p_rows2_reg) + ACC_W'(p_cols2_reg) + RND;
        acc_shr = acc >>> FRAC_BITS;
        if (acc_shr > VMAX)
            nv_sat = VMAX[VALUE_WIDTH-1:0];
        else if (acc_shr < VMIN)
            nv_sat = VMIN[VALUE_WIDTH-1:0];
        else
            nv_sat = acc_shr[VALUE_WIDTH-1:0];
    end

    // ---------------- stage 3: rounded, saturated value ----------------
    meta_t                  m3_reg;
    logic [VALUE_WIDTH-1:0] nv3_reg, old3_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            m3_reg   <= m2_reg;
            nv3_reg  <= nv_sat;
            old3_reg <= old2_reg;
        end
    end

    logic signed [SUM_W-1:0]  diff;
    logic [SUM_W-1:0]         diff_abs;
    logic [VALUE_WIDTH-1:0]   change, max_base, run_max_next;
    logic [VALUE_WIDTH-1:0]   run_max_reg;

    always_comb
    begin
        diff     = $signed({nv3_reg[VALUE_WIDTH-1], nv3_reg})
                 - $signed({old3_reg[VALUE_WIDTH-1], old3_reg});
        diff_abs = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);
        change   = diff_abs[VALUE_WIDTH-1:0];
        max_base = m3_reg.clr ? '0 : run_max_reg;
        run_max_next = (m3_reg.interior && (change > max_base)) ? change : max_base;
    end

    // ---------------- stage 4: running max and output register ----------------
    logic [VALUE_WIDTH-1:0] out_nv_reg;
    logic [ROW_W-1:0]       out_row_reg;
    logic [AW-1:0]          out_col_reg;
    logic                   out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_max_reg <= '0;
        end
        else if (en4 && v3_reg)
        begin
            run_max_reg <= run_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            out_nv_reg   <= nv3_reg;
            out_row_reg  <= m3_reg.row;
            out_col_reg  <= m3_reg.col;
            out_last_reg <= m3_reg.last;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                out_valid_reg <= v3_reg && m3_reg.interior;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({run_max_reg, out_col_reg, out_row_reg, out_nv_reg});

    // ---------------- assertions ----------------
    a_max_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (run_max_reg == m_tdata[OUT_FIELD-1:OUT_FIELD-VALUE_WIDTH]))
        else $error("running max differs from the max on the pending result word");

    a_max_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(run_max_reg))
        else $error("running max moved while the result word was stalled");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_col_reg != '0) && (out_row_reg != '0)))
        else $error("result word for a boundary point");

    a_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_cnt_reg) < 32'(MAX_COLS))
        else $error("column counter beyond line store depth");

endmodule

### rtl/core/jss_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module jss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

### test/jacobi_stencil_sweep_core_test.sv
// Self-checking stream testbench for the Jacobi five-point stencil sweep core.
`timescale 1ns / 1ps

module jacobi_stencil_sweep_core_test;
    import jss_pkg::*;

    localparam int VW      = DEF_VALUE_WIDTH;
    localparam int FB      = DEF_FRAC_BITS;
    localparam int COL_W   = $clog2(DEF_MAX_COLS);
    localparam int IN_W    = ((VW + 7) / 8) * 8;
    localparam int RES_W   = ((2 * VW + ROW_W + COL_W + 7) / 8) * 8;
    localparam int ROW_LO  = VW;
    localparam int COL_LO  = VW + ROW_W;
    localparam int PEAK_LO = VW + ROW_W + COL_W;
    localparam int LIMIT   = 3000000;
    localparam int DRAIN   = 8;
    localparam int RAND_WORDS = 120;

    localparam logic [VW-1:0] V_MAX = {1'b0, {(VW - 1){1'b1}}};
    localparam logic [VW-1:0] V_MIN = {1'b1, {(VW - 1){1'b0}}};

    // One updated interior point as the core reports it
    typedef struct packed {
        logic [VW-1:0]    new_value;
        logic [ROW_W-1:0] point_row;
        logic [COL_W-1:0] point_col;
        logic [VW-1:0]    max_change;
        logic             last_point;
    } point_t;

    // Mirrors the sweep state and holds the updated points still owed by the core.
    class stencil_board;
        bit [ROW_W-1:0]    rows_reg;
        bit [COLS_W-1:0]   cols_reg;
        bit [WEIGHT_W-1:0] wt_rows;
        bit [WEIGHT_W-1:0] wt_cols;
        bit [VW-1:0]       prev_row[];   // row r-1
        bit [VW-1:0]       prev_row2[];  // row r-2
        bit [VW-1:0]       left_tap, mid_tap, right_tap;
        int unsigned       row_pos, col_pos;
        bit [VW-1:0]       peak;
        point_t            pending_points[$];
        int                errors, words, points;

        function new();
            rows_reg  = RST_ROWS_TOTAL;
            cols_reg  = RST_COLS_TOTAL;
            wt_rows   = RST_WEIGHT_ROWS;
            wt_cols   = RST_WEIGHT_COLS;
            prev_row  = new[DEF_MAX_COLS];
            prev_row2 = new[DEF_MAX_COLS];
            foreach (prev_row[i])
            begin
                prev_row[i]  = '0;
                prev_row2[i] = '0;
            end
            left_tap  = '0;
            mid_tap   = '0;
            right_tap = '0;
            row_pos   = 0;
            col_pos   = 0;
            peak      = '0;
            errors    = 0;
            words     = 0;
            points    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_ROWS_TOTAL:  rows_reg = d[ROW_W-1:0];
                CFG_COLS_TOTAL:  cols_reg = d[COLS_W-1:0];
                CFG_WEIGHT_ROWS: wt_rows  = d[WEIGHT_W-1:0];
                CFG_WEIGHT_COLS: wt_cols  = d[WEIGHT_W-1:0];
                default:         ;
            endcase
        endfunction

        // Accepted grid word: advance the window and queue the point it completes.
        function void take_grid_word(logic [VW-1:0] v, logic start);
            int unsigned rows_n, cols_n, r, c, idx;
            longint      up, down, left, right, old, nv, diff, wr, wc, hi, lo;
            point_t      p;
            rows_n = (rows_reg < MIN_EXTENT) ? MIN_EXTENT : rows_reg;
            cols_n = (cols_reg < MIN_EXTENT) ? MIN_EXTENT : cols_reg;
            if (cols_n > DEF_MAX_COLS)
                cols_n = DEF_MAX_COLS;
            if (start)
            begin
                row_pos = 0;
                col_pos = 0;
            end
            r = row_pos;
            c = col_pos;
            if (r == 0 && c == 0)
                peak = '0;
            idx = c % DEF_MAX_COLS;
            words++;

            left_tap  = mid_tap;
            mid_tap   = prev_row[idx];
            right_tap = (idx + 1 < DEF_MAX_COLS) ? prev_row[idx + 1] : '0;

            if (r >= 2 && r <= rows_n - 1 && c >= 1 && c + 2 <= cols_n)
            begin
                up    = $signed(prev_row2[idx]);
                down  = $signed(v);
                left  = $signed(left_tap);
                right = $signed(right_tap);
                old   = $signed(mid_tap);
                wr    = wt_rows;
                wc    = wt_cols;
                hi    = (longint'(1) <<< (VW - 1)) - 1;
                lo    = -hi - 1;
                // round half up: floor of (sum + half) / 2^FB
                nv = ((up + down) * wr + (left + right) * wc
                      + (longint'(1) <<< (FB - 1))) >>> FB;
                if (nv > hi)
                    nv = hi;
                if (nv < lo)
                    nv = lo;
                diff = (nv >= old) ? nv - old : old - nv;
                if (diff > longint'(peak))
                    peak = diff[VW-1:0];
                p.new_value  = nv[VW-1:0];
                p.point_row  = ROW_W'(r - 1);
                p.point_col  = COL_W'(c);
                p.max_change = peak;
                p.last_point = (r == rows_n - 1) && (c == cols_n - 2);
                pending_points.push_back(p);
                points++;
            end

            prev_row2[idx] = prev_row[idx];
            prev_row[idx]  = v;

            if (c + 1 >= cols_n)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= rows_n) ? 0 : r + 1;
            end
            else
                col_pos = c + 1;
        endfunction

        // Result word off the master side: compare against the oldest point.
        function void check_result(logic [RES_W-1:0] data, logic tlast);
            point_t e;
            if (pending_points.size() == 0)
            begin
                $error("result word with no point pending: %h last=%b", data, tlast);
                errors++;
                return;
            end
            e = pending_points.pop_front();
            if (data[VW-1:0] !== e.new_value)
            begin
                $error("new_value: expected %0d, got %0d",
                       $signed(e.new_value), $signed(data[VW-1:0]));
                errors++;
            end
            if (data[ROW_LO +: ROW_W] !== e.point_row)
            begin
                $error("point_row: expected %0d, got %0d",
                       e.point_row, data[ROW_LO +: ROW_W]);
                errors++;
            end
            if (data[COL_LO +: COL_W] !== e.point_col)
            begin
                $error("point_col: expected %0d, got %0d",
                       e.point_col, data[COL_LO +: COL_W]);
                errors++;
            end
            if (data[PEAK_LO +: VW] !== e.max_change)
            begin
                $error("max_change: expected %0d, got %0d",
                       e.max_change, data[PEAK_LO +: VW]);
                errors++;
            end
            if (tlast !== e.last_point)
            begin
                $error("last_point: expected %0b, got %0b", e.last_point, tlast);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;   // [23:0] grid_value
    logic                  s_tuser;   // [0] sweep_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [RES_W-1:0]      m_tdata;   // new_value, point_row, point_col, max_change
    logic                  m_tlast;   // last_point
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stencil_board board;
    int           cycle_count   = 0;
    int           setting_count = 0;
    int           rx_hold_cycles = 0;
    bit           tx_idle = 1;
    bit           rx_idle = 1;

    jacobi_stencil_sweep_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Both handshakes are sampled at the rising edge; inputs only move on the falling one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.take_grid_word(s_tdata[VW-1:0], s_tuser);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tlast);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off when asked for
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Offer one grid word, hold it until taken; entered and left on a falling edge.
    task automatic send_word(input logic [VW-1:0] v, input logic start);
        if (tx_idle && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(v);
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Idle the input and wait out every owed point plus the pipeline tail.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending_points.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        board.set_reg(idx, d);
        @(negedge clk);
    endtask

    // All four registers, written only while the core is empty
    task automatic program_grid(input logic [15:0] rows, input logic [15:0] cols,
                                input logic [15:0] wr, input logic [15:0] wc);
        put_reg(CFG_ROWS_TOTAL, rows);
        put_reg(CFG_COLS_TOTAL, cols);
        put_reg(CFG_WEIGHT_ROWS, wr);
        put_reg(CFG_WEIGHT_COLS, wc);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return V_MAX;
            1:       return V_MIN;
            2:       return VW'($urandom_range(0, 255)) - VW'(128);
            3:       return VW'($urandom_range(0, 1) ? 32'h8000 : 32'h7FFF);
            default: return VW'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Well-formed sweeps with random content; a new sweep may or may not carry
    // sweep_start, and restart_odds sprinkles restarts into the middle of a sweep.
    task automatic run_sweeps(input int n_words, input bit lead_start, input int restart_odds);
        bit start;
        for (int k = 0; k < n_words; k++)
        begin
            start = (k == 0) && lead_start;
            if (k != 0 && board.row_pos == 0 && board.col_pos == 0)
                start = $urandom_range(0, 1);
            else if (restart_odds != 0 && $urandom_range(1, restart_odds) == 1)
                start = 1'b1;
            send_word(pick_value(), start);
        end
    endtask

    initial
    begin
        int rand_words;
        int rows, cols, re, ce, n;

        board     = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ROWS_TOTAL;
        cfg_data  = '0;
        rand_words = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: undersized extents clamp to a 3x3 grid with one interior point.
        // First sweep saturates high from a zero center, the wrapped second sweep
        // saturates low from a full-scale center (largest possible change).
        program_grid(16'd1, 16'd2, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 9; i++)
            send_word((i == 4) ? '0 : V_MAX, i == 0);
        for (int i = 0; i < 9; i++)
            send_word((i == 4) ? V_MAX : V_MIN, 1'b0);
        // restarts in the middle of the first row
        send_word(V_MIN, 1'b1);
        send_word(V_MAX, 1'b0);
        send_word(VW'(1), 1'b1);
        send_word('1, 1'b0);
        settle();

        // Receiver holds off for a long stretch while the grid keeps coming
        program_grid(16'd8, 16'd12, pick_weight(), pick_weight());
        rx_hold_cycles = 300;
        run_sweeps(96, 1'b1, 0);
        settle();

        // Sender pauses mid-sweep until every owed point is out
        program_grid(16'd7, 16'd9, pick_weight(), pick_weight());
        run_sweeps(30, 1'b1, 0);
        settle();
        run_sweeps(33, 1'b0, 0);
        settle();

        // Random grids, mostly small, now and then clamped extents
        while (rand_words < RAND_WORDS)
        begin
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
            cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
            re   = (rows < MIN_EXTENT) ? MIN_EXTENT : rows;
            ce   = (cols < MIN_EXTENT) ? MIN_EXTENT : cols;
            // bits above the 11-bit column register are junk
            program_grid(16'(rows), 16'(($urandom_range(0, 31) << COLS_W) | cols),
                         pick_weight(), pick_weight());
            n = re * ce + $urandom_range(0, ce);
            if (n > RAND_WORDS - rand_words)
                n = RAND_WORDS - rand_words;
            run_sweeps(n, 1'b1, 40);
            settle();
            rand_words += n;
        end

        // Retune between two parts of one sweep: new weights, fewer rows and
        // columns; the position already past the new size wraps on its own.
        program_grid(16'd9, 16'd10, pick_weight(), pick_weight());
        run_sweeps(45, 1'b1, 0);
        settle();
        program_grid(16'd4, 16'd6, pick_weight(), pick_weight());
        run_sweeps(40, 1'b0, 0);
        settle();

        // Oversized column count clamps to the line store depth; the first
        // row is boundary, so no point is owed
        program_grid(16'd3, 16'd2047, pick_weight(), pick_weight());
        run_sweeps(12, 1'b1, 0);
        settle();

        // Final stretch runs with no idling on either side
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        program_grid(16'd6, 16'd11, pick_weight(), pick_weight());
        run_sweeps(60, 1'b1, 20);
        settle();
        // Tallest row count: only the top rows of the grid are visited
        program_grid(16'hFFFF, 16'd3, pick_weight(), pick_weight());
        run_sweeps(12, 1'b1, 0);
        settle();
        repeat (2 * DRAIN) @(negedge clk);

        $display("Swept %0d grid words into %0d checked points over %0d grid settings.",
                 board.words, board.points, setting_count);
        $display("Included clamped extents, saturation both ways, restarts, wraps, stalls.");
        if (board.errors == 0 && board.pending_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
